### rtl/core/vad_pkg.sv
package vad_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int ACC_W     = 64;
  localparam int OPC_W     = 3;

  localparam logic [OPC_W-1:0] OP_ADD   = 3'd0;
  localparam logic [OPC_W-1:0] OP_SUB   = 3'd1;
  localparam logic [OPC_W-1:0] OP_MUL   = 3'd2;
  localparam logic [OPC_W-1:0] OP_SCALE = 3'd3;
  localparam logic [OPC_W-1:0] OP_DOT   = 3'd4;
  localparam logic [OPC_W-1:0] OP_NORM  = 3'd5;

  localparam logic signed [DATA_W-1:0] SCALE_RESET = 32'sd65536;

  localparam logic signed [ACC_W-1:0] MAX32_EXT = 64'sd2147483647;
  localparam logic signed [ACC_W-1:0] MIN32_EXT = -64'sd2147483648;
  localparam logic signed [ACC_W-1:0] MAX64     = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] MIN64     = 64'sh8000_0000_0000_0000;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = 64'sd1 <<< (FRAC_BITS - 1);

  localparam logic [DATA_W-1:0] MAX32 = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] MIN32 = 32'h8000_0000;

  // Queue depth must stay a power of two.
  localparam int FIFO_AW    = 2;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;

  localparam int SQ_STEPS = ACC_W / 2;
  localparam int SQ_CW    = $clog2(SQ_STEPS);
  localparam int SQ_REM_W = DATA_W + 4;

  typedef enum logic [2:0] {
    K_ADD,
    K_SUB,
    K_MUL,
    K_SCALE,
    K_DOT,
    K_NORM
  } kind_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_FIN,
    ST_SQRT
  } state_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic                     last;
  } item_t;

  typedef struct packed {
    logic              sat;
    logic [DATA_W-1:0] value;
  } res_t;

  function automatic res_t sat32(input logic signed [ACC_W-1:0] v);
    res_t r;
    if (v > MAX32_EXT) begin
      r.sat   = 1'b1;
      r.value = MAX32;
    end else if (v < MIN32_EXT) begin
      r.sat   = 1'b1;
      r.value = MIN32;
    end else begin
      r.sat   = 1'b0;
      r.value = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/vector_alu_dot_norm_top.sv
// An elementwise word passes the queue, stage 1 and output registers to out_tvalid.
// A final dot word then passes ST_FIN; a final norm word runs the 32-step square root
// in ST_FIN and ST_SQRT. One word per cycle for elementwise and non-final dot or norm
// words, while the output accepts and no vector end holds the back end in those states.
// Reset is synchronous and active low: it empties the queue, clears the accumulator
// and its overflow flag, and sets scale_factor to 1.0 (65536).
module vector_alu_dot_norm_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,   // scale_factor
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,      // a_value [31:0], b_value [63:32]
  input  logic [2:0]  in_tuser,      // opcode [2:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,     // result_value [31:0]
  output logic        out_tuser,     // saturated [0]
  output logic        out_tlast
);

  logic           fifo_full;
  logic           push;
  vad_pkg::item_t push_item;
  logic           pop;
  logic           head_valid;
  vad_pkg::item_t head_item;

  vad_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .fifo_full (fifo_full),
    .push      (push),
    .push_item (push_item)
  );

  vad_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (fifo_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  vad_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .head_valid  (head_valid),
    .head_item   (head_item),
    .pop         (pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

endmodule

### rtl/core/vad_front.sv
module vad_front (
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [63:0]                   in_tdata,
  input  logic [vad_pkg::OPC_W-1:0]     in_tuser,
  input  logic                          in_tlast,
  input  logic                          fifo_full,
  output logic                          push,
  output vad_pkg::item_t                push_item
);

  logic  opc_ok;
  vad_pkg::kind_t kind;

  always_comb begin
    opc_ok = 1'b1;
    kind   = vad_pkg::K_ADD;
    unique case (in_tuser)
      vad_pkg::OP_ADD:   kind = vad_pkg::K_ADD;
      vad_pkg::OP_SUB:   kind = vad_pkg::K_SUB;
      vad_pkg::OP_MUL:   kind = vad_pkg::K_MUL;
      vad_pkg::OP_SCALE: kind = vad_pkg::K_SCALE;
      vad_pkg::OP_DOT:   kind = vad_pkg::K_DOT;
      vad_pkg::OP_NORM:  kind = vad_pkg::K_NORM;
      default:           opc_ok = 1'b0;
    endcase
  end

  assign in_tready      = !fifo_full;
  assign push           = in_tvalid && !fifo_full && opc_ok;
  assign push_item.kind = kind;
  assign push_item.a    = in_tdata[31:0];
  assign push_item.b    = in_tdata[63:32];
  assign push_item.last = in_tlast;

endmodule

### rtl/core/vad_fifo.sv
module vad_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  vad_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output vad_pkg::item_t head_item
);

  vad_pkg::item_t                mem_r [vad_pkg::FIFO_DEPTH];
  logic [vad_pkg::FIFO_AW-1:0]   wr_ptr_r;
  logic [vad_pkg::FIFO_AW-1:0]   rd_ptr_r;
  logic [vad_pkg::FIFO_AW:0]     count_r;
  logic [vad_pkg::FIFO_AW:0]     count_nxt;

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  assign full       = count_r[vad_pkg::FIFO_AW];
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= vad_pkg::FIFO_DEPTH)
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("queue popped while empty");

endmodule

### rtl/core/vad_sqrt.sv
module vad_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [vad_pkg::ACC_W-1:0]   radicand,
  output logic                        busy,
  output logic [vad_pkg::DATA_W-1:0]  root
);

  logic                          busy_r;
  logic [vad_pkg::SQ_CW-1:0]     cnt_r;
  logic [vad_pkg::ACC_W-1:0]     n_r;
  logic [vad_pkg::SQ_REM_W-1:0]  rem_r;
  logic [vad_pkg::DATA_W-1:0]    root_r;
  logic [vad_pkg::SQ_REM_W-1:0]  rem_sh;
  logic [vad_pkg::SQ_REM_W-1:0]  trial;
  logic                          ge;

  assign rem_sh = {rem_r[vad_pkg::SQ_REM_W-3:0], n_r[vad_pkg::ACC_W-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == vad_pkg::SQ_CW'(vad_pkg::SQ_STEPS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      n_r    <= n_r << 2;
      rem_r  <= ge ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[vad_pkg::DATA_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

### rtl/core/vad_back.sv
module vad_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [31:0]                  cfg_wr_data,
  input  logic                         head_valid,
  input  vad_pkg::item_t               head_item,
  output logic                         pop,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [31:0]                  out_tdata,
  output logic                         out_tlast,
  output logic                         out_tuser
);

  vad_pkg::state_t                       state_r;
  vad_pkg::state_t                       state_nxt;
  logic signed [vad_pkg::DATA_W-1:0]     scale_r;
  logic                                  s1_valid_r;
  vad_pkg::item_t                        s1_item_r;
  logic signed [vad_pkg::ACC_W-1:0]      s1_prod_r;
  logic signed [vad_pkg::ACC_W-1:0]      acc_r;
  logic                                  acc_ovf_r;
  logic                                  fin_norm_r;
  logic                                  out_valid_r;
  logic [vad_pkg::DATA_W-1:0]            out_value_r;
  logic                                  out_last_r;
  logic                                  out_sat_r;

  logic signed [vad_pkg::DATA_W-1:0]     mul_a;
  logic signed [vad_pkg::DATA_W-1:0]     mul_b;
  logic signed [vad_pkg::ACC_W-1:0]      prod;
  logic signed [vad_pkg::DATA_W:0]       add_sum;
  logic signed [vad_pkg::DATA_W:0]       sub_diff;
  logic signed [vad_pkg::ACC_W-1:0]      rnd;
  logic signed [vad_pkg::ACC_W-1:0]      rnd_q;
  logic [vad_pkg::ACC_W:0]               acc_sum;
  logic                                  acc_wrap;
  logic signed [vad_pkg::ACC_W-1:0]      dot_q;
  vad_pkg::res_t                         ew_res;
  vad_pkg::res_t                         fin_res;
  logic [vad_pkg::DATA_W-1:0]            sq_root;
  logic                                  sq_busy;
  logic                                  sq_start;
  logic                                  slot_free;
  logic                                  s1_ew;
  logic                                  s1_fire;
  logic                                  acc_en;
  logic                                  ew_emit;
  logic                                  fin_emit;

  // Stage 1 operand selection and product.
  always_comb begin
    mul_a = head_item.a;
    unique case (head_item.kind)
      vad_pkg::K_SCALE: mul_b = scale_r;
      vad_pkg::K_NORM:  mul_b = head_item.a;
      default:          mul_b = head_item.b;
    endcase
  end

  assign prod = mul_a * mul_b;

  // Elementwise results.
  assign add_sum  = $signed({s1_item_r.a[31], s1_item_r.a})
                  + $signed({s1_item_r.b[31], s1_item_r.b});
  assign sub_diff = $signed({s1_item_r.a[31], s1_item_r.a})
                  - $signed({s1_item_r.b[31], s1_item_r.b});
  assign rnd      = s1_prod_r + vad_pkg::ROUND_HALF;
  assign rnd_q    = rnd >>> vad_pkg::FRAC_BITS;

  always_comb begin
    unique case (s1_item_r.kind)
      vad_pkg::K_ADD: ew_res = vad_pkg::sat32({{31{add_sum[32]}}, add_sum});
      vad_pkg::K_SUB: ew_res = vad_pkg::sat32({{31{sub_diff[32]}}, sub_diff});
      default:        ew_res = vad_pkg::sat32(rnd_q);
    endcase
  end

  // Saturating accumulate.
  assign acc_sum  = {acc_r[vad_pkg::ACC_W-1], acc_r}
                  + {s1_prod_r[vad_pkg::ACC_W-1], s1_prod_r};
  assign acc_wrap = acc_sum[vad_pkg::ACC_W] ^ acc_sum[vad_pkg::ACC_W-1];

  // Vector end results.
  assign dot_q = (acc_r >>> vad_pkg::FRAC_BITS)
               + $signed({{(vad_pkg::ACC_W-1){1'b0}}, acc_r[vad_pkg::FRAC_BITS-1]});

  always_comb begin
    if (acc_ovf_r) begin
      fin_res.sat   = 1'b1;
      fin_res.value = acc_r[vad_pkg::ACC_W-1] ? vad_pkg::MIN32 : vad_pkg::MAX32;
    end else if (fin_norm_r) begin
      fin_res.sat   = sq_root[vad_pkg::DATA_W-1];
      fin_res.value = sq_root[vad_pkg::DATA_W-1] ? vad_pkg::MAX32 : sq_root;
    end else begin
      fin_res = vad_pkg::sat32(dot_q);
    end
  end

  vad_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (acc_r[vad_pkg::ACC_W-1] ? '0 : acc_r),
    .busy     (sq_busy),
    .root     (sq_root)
  );

  assign slot_free = !out_valid_r || out_tready;
  assign s1_ew     = (s1_item_r.kind != vad_pkg::K_DOT) && (s1_item_r.kind != vad_pkg::K_NORM);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vad_pkg::ST_RUN: begin
        if (s1_valid_r && !s1_ew && s1_item_r.last) begin
          state_nxt = vad_pkg::ST_FIN;
        end
      end
      vad_pkg::ST_FIN: begin
        if (fin_norm_r && !acc_ovf_r) begin
          state_nxt = vad_pkg::ST_SQRT;
        end else if (slot_free) begin
          state_nxt = vad_pkg::ST_RUN;
        end
      end
      vad_pkg::ST_SQRT: begin
        if (!sq_busy && slot_free) begin
          state_nxt = vad_pkg::ST_RUN;
        end
      end
      default: state_nxt = vad_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    s1_fire  = 1'b0;
    sq_start = 1'b0;
    fin_emit = 1'b0;
    unique case (state_r)
      vad_pkg::ST_RUN:  s1_fire  = s1_valid_r && (!s1_ew || slot_free);
      vad_pkg::ST_FIN: begin
        sq_start = fin_norm_r && !acc_ovf_r;
        fin_emit = !(fin_norm_r && !acc_ovf_r) && slot_free;
      end
      vad_pkg::ST_SQRT: fin_emit = !sq_busy && slot_free;
      default: begin
        s1_fire = 1'b0;
      end
    endcase
  end

  assign acc_en  = s1_fire && !s1_ew;
  assign ew_emit = s1_fire && s1_ew;
  assign pop     = head_valid && (!s1_valid_r || s1_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vad_pkg::ST_RUN;
      scale_r     <= vad_pkg::SCALE_RESET;
      s1_valid_r  <= 1'b0;
      acc_r       <= '0;
      acc_ovf_r   <= 1'b0;
      fin_norm_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        scale_r <= cfg_wr_data;
      end
      if (pop) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (fin_emit) begin
        acc_r     <= '0;
        acc_ovf_r <= 1'b0;
      end else if (acc_en) begin
        if (acc_wrap) begin
          acc_r     <= s1_prod_r[vad_pkg::ACC_W-1] ? vad_pkg::MIN64 : vad_pkg::MAX64;
          acc_ovf_r <= 1'b1;
        end else begin
          acc_r <= acc_sum[vad_pkg::ACC_W-1:0];
        end
      end
      if (acc_en && s1_item_r.last) begin
        fin_norm_r <= (s1_item_r.kind == vad_pkg::K_NORM);
      end
      if (slot_free) begin
        out_valid_r <= ew_emit || fin_emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_item_r <= head_item;
      s1_prod_r <= prod;
    end
    if (ew_emit) begin
      out_value_r <= ew_res.value;
      out_sat_r   <= ew_res.sat;
      out_last_r  <= s1_item_r.last;
    end else if (fin_emit) begin
      out_value_r <= fin_res.value;
      out_sat_r   <= fin_res.sat;
      out_last_r  <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_sat_r;

  a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    fin_emit |=> (acc_r == '0 && !acc_ovf_r))
    else $error("accumulator not cleared after vector end");

  a_sqrt_idle_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == vad_pkg::ST_RUN |-> !sq_busy)
    else $error("square root unit busy while streaming");

endmodule
